@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication form of the same check.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/pbps_pkg.sv @@
package pbps_pkg;

  // Width of the tick counter that runs in every mode.
  localparam int unsigned TickBits    = 16;
  localparam int unsigned TimeoutBits = 16;
  localparam int unsigned CmpBits     = (TickBits > TimeoutBits) ? TickBits : TimeoutBits;

  localparam logic [TimeoutBits-1:0] TimeoutReset = TimeoutBits'(5000);

  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 16;

  // Mode numbers as they appear on the result stream.
  localparam logic [2:0] ModeIdle = 3'd2;
  localparam logic [2:0] ModeOn   = 3'd6;
  localparam logic [2:0] ModeWOff = 3'd7;

  typedef struct packed {
    logic [1:0] button_event;
    logic       tone_busy;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       sleep_request;
    logic       melody_repeat;
    logic [2:0] melody_id;
    logic [1:0] tone_cmd;
    logic [2:0] blink_count;
    logic [1:0] led_cmd;
    logic       fet_on;
  } result_t;

endpackage

@@ sv/pbps_in_stage.sv @@
`include "assert_macros.svh"

module pbps_in_stage import pbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [InDataBits-1:0] in_data_i,
  input  logic                  take_i,
  output logic                  item_valid_o,
  output in_item_t              item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q, item_d;
  logic     load;

  // The slot frees up in the same cycle that the held item moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d             = 1'b1;
      item_d.button_event = in_data_i[1:0];
      item_d.tone_busy    = in_data_i[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  `ASSERT_IMPL(a_take_needs_item, clk_i, rst_ni, take_i, valid_q, "item taken from an empty slot")

endmodule

@@ sv/pbps_fsm.sv @@
`include "assert_macros.svh"

module pbps_fsm import pbps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  in_item_t               item_i,
  input  logic [TimeoutBits-1:0] timeout_i,
  output result_t                res_o
);

  typedef enum logic [2:0] {
    M_INIT       = 3'd0,
    M_STARTUP    = 3'd1,
    M_IDLE       = 3'd2,
    M_WAIT_SLEEP = 3'd3,
    M_SLEEP      = 3'd4,
    M_WAIT_ON    = 3'd5,
    M_ON         = 3'd6,
    M_WAIT_OFF   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_OFF   = 2'd1,
    LED_BLINK = 2'd2
  } led_e;

  typedef enum logic [1:0] {
    TONE_NONE      = 2'd0,
    TONE_STOP      = 2'd1,
    TONE_PLAY      = 2'd2,
    TONE_STOP_PLAY = 2'd3
  } tone_e;

  typedef enum logic [2:0] {
    MEL_START    = 3'd0,
    MEL_SLEEP    = 3'd1,
    MEL_WAIT_ON  = 3'd2,
    MEL_WAIT_OFF = 3'd3,
    MEL_ON       = 3'd4
  } melody_e;

  localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

  mode_e                mode_q, mode_d, nxt;
  logic [TickBits-1:0]  ticks_q, ticks_d, ticks_inc;
  logic                 fet_q, fet_d;
  result_t              res_q, res_d;
  event_e               ev;
  led_e                 led;
  tone_e                tone;
  melody_e              mel;
  logic [2:0]           blink;
  logic                 rep, slp, timed_out;

  assign ev        = event_e'(item_i.button_event);
  assign ticks_inc = (ticks_q == TickMax) ? ticks_q : ticks_q + 1'b1;
  assign timed_out = CmpBits'(ticks_inc) > CmpBits'(timeout_i);

  always_comb begin
    nxt   = mode_q;
    fet_d = fet_q;
    led   = LED_KEEP;
    blink = 3'd0;
    tone  = TONE_NONE;
    mel   = MEL_START;
    rep   = 1'b0;
    slp   = 1'b0;

    unique case (mode_q)
      M_INIT: begin
        fet_d = 1'b0;
        tone  = TONE_PLAY;
        nxt   = M_STARTUP;
      end
      M_STARTUP:    if (!item_i.tone_busy) nxt = M_IDLE;
      M_IDLE: begin
        if (timed_out) nxt = M_WAIT_SLEEP;
        else if (ev == EV_SHORT) nxt = M_WAIT_ON;
      end
      M_WAIT_SLEEP: if (!item_i.tone_busy) nxt = M_SLEEP;
      M_SLEEP:      if (ev == EV_SHORT) nxt = M_WAIT_ON;
      M_WAIT_ON: begin
        if (ev == EV_LONG) nxt = M_ON;
        else if (ev == EV_RELEASE) nxt = M_IDLE;
      end
      M_ON:         if (ev == EV_SHORT) nxt = M_WAIT_OFF;
      M_WAIT_OFF: begin
        if (ev == EV_LONG) nxt = M_IDLE;
        else if (ev == EV_RELEASE) nxt = M_ON;
      end
      default: nxt = mode_q;
    endcase

    ticks_d = ticks_inc;
    mode_d  = nxt;
    if (nxt != mode_q) begin
      ticks_d = '0;
      unique case (nxt)
        M_STARTUP: fet_d = 1'b0;
        M_WAIT_SLEEP: begin
          led  = LED_OFF;
          tone = TONE_PLAY;
          mel  = MEL_SLEEP;
        end
        M_SLEEP: begin
          // Sleep is left at once: power down is requested and the block
          // wakes in idle without the idle entry actions.
          fet_d  = 1'b0;
          led    = LED_OFF;
          slp    = 1'b1;
          mode_d = M_IDLE;
        end
        M_WAIT_ON: begin
          led   = LED_BLINK;
          blink = 3'd2;
          tone  = TONE_PLAY;
          mel   = MEL_WAIT_ON;
          rep   = 1'b1;
        end
        M_ON: begin
          led   = LED_BLINK;
          blink = 3'd5;
          tone  = TONE_STOP_PLAY;
          mel   = MEL_ON;
          rep   = 1'b1;
          fet_d = 1'b1;
        end
        M_WAIT_OFF: begin
          led   = LED_BLINK;
          blink = 3'd3;
          tone  = TONE_PLAY;
          mel   = MEL_WAIT_OFF;
          rep   = 1'b1;
        end
        M_IDLE: begin
          tone  = TONE_STOP;
          led   = LED_BLINK;
          blink = 3'd1;
          fet_d = 1'b0;
        end
        default: ;
      endcase
    end

    res_d.fet_on        = fet_d;
    res_d.led_cmd       = led;
    res_d.blink_count   = blink;
    res_d.tone_cmd      = tone;
    res_d.melody_id     = mel;
    res_d.melody_repeat = rep;
    res_d.sleep_request = slp;
    res_d.mode          = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_INIT;
      ticks_q <= '0;
      fet_q   <= 1'b0;
      res_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
      fet_q   <= fet_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

  `ASSERT_CLK(a_sleep_never_held, clk_i, rst_ni, mode_q != M_SLEEP, "sleep mode was held")
  `ASSERT_IMPL(a_fet_only_armed, clk_i, rst_ni, fet_q, (mode_q == M_ON) || (mode_q == M_WAIT_OFF),
    "load enabled outside on and wait_off")

endmodule

@@ sv/push_button_power_switch_fsm_core.sv @@
// Soft power switch controller. Each transfer on the slave stream is one
// timer tick carrying the debounced button event and the tone player's busy
// flag; each tick yields exactly one result transfer on the master stream
// with the load switch enable, LED and tone commands, the sleep request and
// the mode after the tick. The block takes one tick per clock cycle when the
// downstream side keeps up: a tick is held in an input register, the whole
// next-state rule runs as one combinational step into the result register,
// and the result register drives the master stream. The idle timeout
// register is written through cfg_we_i/cfg_wdata_i and should only
// change while no tick is in flight.
`include "assert_macros.svh"

module push_button_power_switch_fsm_core import pbps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Idle timeout in ticks.
  input  logic                    cfg_we_i,
  input  logic [TimeoutBits-1:0]  cfg_wdata_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // [1:0] button_event, [2] tone_busy, [7:3] zero.
  input  logic [InDataBits-1:0]   s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // [0] fet_on, [2:1] led_cmd, [5:3] blink_count, [7:6] tone_cmd,
  // [10:8] melody_id, [11] melody_repeat, [12] sleep_request, [15:13] mode.
  output logic [OutDataBits-1:0]  m_axis_tdata_o
);

  logic [TimeoutBits-1:0] timeout_q;
  logic                   item_valid;
  in_item_t               item;
  logic                   step;
  logic                   out_valid_q, out_valid_d;
  result_t                res;

  // The idle timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // A held tick is evaluated whenever the result register is empty or its
  // current result is being transferred out in this cycle.
  assign step = item_valid && (!out_valid_q || m_axis_tready_i);

  pbps_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  pbps_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (item),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res;

  `ASSERT_IMPL(a_step_fills_result, clk_i, rst_ni, step, ##1 out_valid_q,
    "evaluated tick left no result")
  `ASSERT_IMPL(a_sleep_req_in_idle, clk_i, rst_ni, out_valid_q && res.sleep_request,
    res.mode == ModeIdle, "sleep request without idle mode")

endmodule

@@ dv/power_switch_checker.sv @@
`timescale 1ns / 100ps

package pbps_tb_pkg;

  import pbps_pkg::*;

  typedef enum logic [2:0] {
    MODE_INIT       = 3'd0,
    MODE_STARTUP    = 3'd1,
    MODE_IDLE       = ModeIdle,
    MODE_WAIT_SLEEP = 3'd3,
    MODE_SLEEP      = 3'd4,
    MODE_WAIT_ON    = 3'd5,
    MODE_ON         = ModeOn,
    MODE_WAIT_OFF   = ModeWOff
  } pwr_mode_e;

  typedef enum logic [1:0] {
    BTN_NONE    = 2'd0,
    BTN_SHORT   = 2'd1,
    BTN_LONG    = 2'd2,
    BTN_RELEASE = 2'd3
  } btn_event_e;

  typedef enum logic [1:0] {
    LED_KEEP  = 2'd0,
    LED_OFF   = 2'd1,
    LED_BLINK = 2'd2
  } led_cmd_e;

  typedef enum logic [1:0] {
    TONE_NONE    = 2'd0,
    TONE_STOP    = 2'd1,
    TONE_PLAY    = 2'd2,
    TONE_RESTART = 2'd3
  } tone_cmd_e;

  typedef enum logic [2:0] {
    MEL_START    = 3'd0,
    MEL_SLEEP    = 3'd1,
    MEL_WAIT_ON  = 3'd2,
    MEL_WAIT_OFF = 3'd3,
    MEL_ON       = 3'd4
  } melody_e;

endpackage

module power_switch_checker
  import pbps_pkg::*;
  import pbps_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [TimeoutBits-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [InDataBits-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OutDataBits-1:0] m_axis_tdata_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o,
  output int unsigned            checked_o,
  output int unsigned            sleeps_o
);

  pwr_mode_e              mode_q;
  logic [TickBits-1:0]    ticks_q;
  logic                   fet_q;
  logic [TimeoutBits-1:0] timeout_q;
  result_t                expected_results_q[$];

  // Advances the controller by one tick and returns the result it owes.
  function automatic result_t predict_tick(input btn_event_e ev, input logic busy);
    result_t   r;
    pwr_mode_e cur_mode;
    pwr_mode_e nxt_mode;
    r = '0;
    if (ticks_q != '1) ticks_q = ticks_q + 1'b1;
    cur_mode = mode_q;
    nxt_mode = mode_q;
    case (mode_q)
      MODE_INIT: begin
        fet_q       = 1'b0;
        r.tone_cmd  = TONE_PLAY;
        r.melody_id = MEL_START;
        nxt_mode    = MODE_STARTUP;
      end
      MODE_STARTUP:    if (!busy) nxt_mode = MODE_IDLE;
      MODE_IDLE: begin
        if (ticks_q > timeout_q) nxt_mode = MODE_WAIT_SLEEP;
        else if (ev == BTN_SHORT) nxt_mode = MODE_WAIT_ON;
      end
      MODE_WAIT_SLEEP: if (!busy) nxt_mode = MODE_SLEEP;
      MODE_SLEEP:      if (ev == BTN_SHORT) nxt_mode = MODE_WAIT_ON;
      MODE_WAIT_ON: begin
        if (ev == BTN_LONG) nxt_mode = MODE_ON;
        else if (ev == BTN_RELEASE) nxt_mode = MODE_IDLE;
      end
      MODE_ON:         if (ev == BTN_SHORT) nxt_mode = MODE_WAIT_OFF;
      default: begin
        if (ev == BTN_LONG) nxt_mode = MODE_IDLE;
        else if (ev == BTN_RELEASE) nxt_mode = MODE_ON;
      end
    endcase

    // Entry actions; sleep is only passed through on the way back to idle.
    if (nxt_mode != cur_mode) begin
      ticks_q = '0;
      case (nxt_mode)
        MODE_STARTUP: fet_q = 1'b0;
        MODE_WAIT_SLEEP: begin
          r.led_cmd   = LED_OFF;
          r.tone_cmd  = TONE_PLAY;
          r.melody_id = MEL_SLEEP;
        end
        MODE_SLEEP: begin
          fet_q           = 1'b0;
          r.led_cmd       = LED_OFF;
          r.sleep_request = 1'b1;
          nxt_mode        = MODE_IDLE;
        end
        MODE_WAIT_ON: begin
          r.led_cmd       = LED_BLINK;
          r.blink_count   = 3'd2;
          r.tone_cmd      = TONE_PLAY;
          r.melody_id     = MEL_WAIT_ON;
          r.melody_repeat = 1'b1;
        end
        MODE_ON: begin
          r.led_cmd       = LED_BLINK;
          r.blink_count   = 3'd5;
          r.tone_cmd      = TONE_RESTART;
          r.melody_id     = MEL_ON;
          r.melody_repeat = 1'b1;
          fet_q           = 1'b1;
        end
        MODE_WAIT_OFF: begin
          r.led_cmd       = LED_BLINK;
          r.blink_count   = 3'd3;
          r.tone_cmd      = TONE_PLAY;
          r.melody_id     = MEL_WAIT_OFF;
          r.melody_repeat = 1'b1;
        end
        MODE_IDLE: begin
          r.tone_cmd    = TONE_STOP;
          r.led_cmd     = LED_BLINK;
          r.blink_count = 3'd1;
          fet_q         = 1'b0;
        end
        default: ;
      endcase
    end
    mode_q = nxt_mode;
    r.fet_on = fet_q;
    r.mode   = mode_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      mode_q       = MODE_INIT;
      ticks_q      = '0;
      fet_q        = 1'b0;
      timeout_q    = TimeoutReset;
      expected_results_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
      sleeps_o     = 0;
    end else begin
      if (cfg_we_i) timeout_q = cfg_wdata_i;
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_results_q.size() == 0) begin
          $error("result transfer %h arrived with no tick outstanding", m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("fet_on", want.fet_on, got.fet_on);
          check_field("led_cmd", want.led_cmd, got.led_cmd);
          check_field("blink_count", want.blink_count, got.blink_count);
          check_field("tone_cmd", want.tone_cmd, got.tone_cmd);
          check_field("melody_id", want.melody_id, got.melody_id);
          check_field("melody_repeat", want.melody_repeat, got.melody_repeat);
          check_field("sleep_request", want.sleep_request, got.sleep_request);
          check_field("mode", want.mode, got.mode);
          checked_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = predict_tick(btn_event_e'(s_axis_tdata_i[1:0]), s_axis_tdata_i[2]);
        if (want.sleep_request) sleeps_o++;
        expected_results_q.push_back(want);
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

// Top of the power switch controller bench. This module produces ticks,
// configuration writes, downstream back-pressure and the hang watchdog; all
// prediction and comparison live in the checker instance beside the block.
module tb_top;

  import pbps_pkg::*;
  import pbps_tb_pkg::*;

  // Cycles without any transfer before the run is declared hung. This leaves
  // a wide margin over the random gaps and stalls and over a drain plus a
  // register write.
  localparam int unsigned StallLimit = 1000;
  // Random ticks per idle timeout setting; with the directed part the run
  // comes to about 1350 ticks.
  localparam int unsigned PhaseTicks = 240;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [TimeoutBits-1:0] cfg_wdata;
  logic                   s_valid;
  logic                   s_ready;
  logic [InDataBits-1:0]  s_data;
  logic                   m_valid;
  logic                   m_ready;
  logic [OutDataBits-1:0] m_data;

  // When calm is set neither side inserts gaps or stalls.
  logic                   calm;
  // Input transfer flag sampled at the rising edge, read by the stimulus at
  // the following falling edge, so the sender never races the block's outputs.
  logic                   in_fire;
  int unsigned            quiet_cycles = 0;
  int unsigned            ticks_sent = 0;
  int unsigned            settings_used = 1;
  int unsigned            phase_start;
  logic [TimeoutBits-1:0] phase_timeouts [5];

  int unsigned            pending;
  int unsigned            fail_count;
  int unsigned            checked;
  int unsigned            sleeps;

  always #5 clk = ~clk;

  push_button_power_switch_fsm_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  power_switch_checker chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .checked_o       (checked),
    .sleeps_o        (sleeps)
  );

  // Transfer flag and the hang watchdog. The counter restarts on any
  // transfer in either direction and is held at zero while reset is asserted.
  always @(posedge clk) begin
    in_fire  <= s_valid && s_ready;
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("no transfer for %0d cycles, giving up", StallLimit);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Downstream side: stalls in about 11 percent of cycles unless calm.
  always @(negedge clk) begin
    m_ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  function automatic logic busy_coin();
    return $urandom_range(0, 99) < 35;
  endfunction

  // Presents one tick, possibly after an idle gap of random length, and returns at the
  // falling edge right after the rising edge that took it. tvalid stays high
  // on return so that a following call can present the next tick with no gap.
  task automatic send_tick(input btn_event_e ev, input logic busy);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_valid <= 1'b0;
      s_data  <= InDataBits'($urandom);
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= InDataBits'({busy, ev});
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    ticks_sent++;
  endtask

  // Stops the sender and waits for every outstanding result before returning.
  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idle_timeout(input logic [TimeoutBits-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // One random user gesture. Half are well-formed press sequences (arm,
  // disarm, cancel) with random waits and busy flags; runs of quiet ticks let
  // the idle timeout expire, and the rest are arbitrary single ticks.
  task automatic send_gesture();
    int unsigned pick;
    int unsigned waits;
    pick  = $urandom_range(0, 99);
    waits = $urandom_range(0, 3);
    if (pick < 35) begin
      send_tick(BTN_SHORT, busy_coin());
      repeat (waits) send_tick(BTN_NONE, busy_coin());
      send_tick(BTN_LONG, busy_coin());
    end else if (pick < 50) begin
      send_tick(BTN_SHORT, busy_coin());
      repeat (waits) send_tick(BTN_NONE, busy_coin());
      send_tick(BTN_RELEASE, busy_coin());
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 30)) send_tick(BTN_NONE, busy_coin());
    end else begin
      send_tick(btn_event_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    m_ready   = 1'b0;
    calm      = 1'b0;
    in_fire   = 1'b0;
    phase_timeouts = '{16'd1, 16'd6, 16'd25, 16'd0, 16'd300};
    phase_timeouts[3] = TimeoutBits'($urandom_range(0, 80));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed walk outside the sleep path at the reset timeout. The first tick
    // leaves init with the start melody while the player is still busy, so
    // startup must hold until the busy flag drops.
    send_tick(BTN_NONE, 1'b1);
    send_tick(BTN_SHORT, 1'b1);
    send_tick(BTN_NONE, 1'b0);
    // Idle ignores long presses and releases; a short press starts arming.
    send_tick(BTN_LONG, 1'b0);
    send_tick(BTN_RELEASE, 1'b0);
    send_tick(BTN_SHORT, 1'b1);
    send_tick(BTN_NONE, 1'b0);
    send_tick(BTN_SHORT, 1'b0);
    // Releasing without the confirmation press cancels back to idle.
    send_tick(BTN_RELEASE, 1'b0);
    send_tick(BTN_SHORT, 1'b0);
    // The long press confirms arming and turns the load on.
    send_tick(BTN_LONG, 1'b1);
    send_tick(BTN_LONG, 1'b0);
    send_tick(BTN_RELEASE, 1'b0);
    // Disarming: a release returns to on, a long press confirms the switch-off.
    send_tick(BTN_SHORT, 1'b0);
    send_tick(BTN_SHORT, 1'b1);
    send_tick(BTN_RELEASE, 1'b0);
    send_tick(BTN_SHORT, 1'b0);
    send_tick(BTN_LONG, 1'b0);

    // A timeout of zero puts idle into the sleep path on its first tick, even
    // ahead of a short press. Leaving sleep raises the sleep request and lands
    // in idle without the idle entry commands.
    set_idle_timeout('0);
    send_tick(BTN_NONE, 1'b1);
    send_tick(BTN_SHORT, 1'b1);
    send_tick(BTN_NONE, 1'b0);
    send_tick(BTN_SHORT, 1'b0);
    send_tick(BTN_NONE, 1'b0);

    // A long stretch with no gaps or stalls on either side. Idle runs out a
    // few times at a moderate timeout, with the busy flag holding the sleep
    // melody for random stretches.
    set_idle_timeout(TimeoutBits'(40));
    calm = 1'b1;
    repeat (120) send_tick(BTN_NONE, busy_coin());
    calm = 1'b0;

    // Random gestures under several timeouts. Each write waits for the block
    // to drain, so the sender pauses until every result is back.
    foreach (phase_timeouts[i]) begin
      set_idle_timeout(phase_timeouts[i]);
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PhaseTicks) send_gesture();
    end

    drain();
    repeat (6) @(negedge clk);

    $display("Covered %0d ticks under %0d idle timeout settings, zero timeout included.",
             ticks_sent, settings_used);
    $display("Compared %0d results, %0d of them with a sleep request.",
             checked, sleeps);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
